// ===== src/rlrgm_pkg.sv =====
// Shared constants, codes and types of the ring resampler / gain mixer.
// No dependencies; the other files but rlrgm_ram refer to it, by scoped names or, in the testbench, by import.
package rlrgm_pkg;

  // Ring geometry (power of two). The position counters carry one extra wrap bit.
  localparam int RING_FRAMES = 4096;
  localparam int RING_AW     = $clog2(RING_FRAMES);
  localparam int CNT_W       = RING_AW + 1;

  // Field widths
  localparam int ACT_W      = 3;
  localparam int SAMP_W     = 16;
  localparam int FRAME_W    = 2 * SAMP_W;
  localparam int SUM_W      = 32;
  localparam int STEP_W     = 20;
  localparam int GAIN_W     = 15;
  localparam int FRAC_W     = 16;
  localparam int T_W        = FRAC_W - 1;
  localparam int PHACC_W    = STEP_W + 1;
  localparam int ADV_W      = PHACC_W - FRAC_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = STEP_W;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MIX   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_START = 3'd2;
  localparam logic [ACT_W-1:0] ACT_END   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'd1;

  // Register reset values: unity step, unity gain
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIFF,
    S_MUL1,
    S_MUL2,
    S_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic diff;
    logic mul1;
    logic mul2;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mix_go;
  } dp_status_t;

endpackage

// ===== src/rlrgm_in_if.sv =====
// Input item channel: valid/ready handshake plus action and payload fields.
// Depends on rlrgm_pkg for field widths.
interface rlrgm_in_if;
  logic                                valid;
  logic                                ready;
  logic [rlrgm_pkg::ACT_W-1:0]         action;
  logic signed [rlrgm_pkg::SAMP_W-1:0] in_left;
  logic signed [rlrgm_pkg::SAMP_W-1:0] in_right;
  logic signed [rlrgm_pkg::SUM_W-1:0]  accum_left;
  logic signed [rlrgm_pkg::SUM_W-1:0]  accum_right;

  modport source (output valid, action, in_left, in_right, accum_left, accum_right,
                  input ready);
  modport sink   (input valid, action, in_left, in_right, accum_left, accum_right,
                  output ready);
endinterface

// ===== src/rlrgm_out_if.sv =====
// Result item channel: valid/ready handshake plus mixed sums and status flags.
// Depends on rlrgm_pkg for field widths.
interface rlrgm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rlrgm_pkg::SUM_W-1:0] sum_left;
  logic signed [rlrgm_pkg::SUM_W-1:0] sum_right;
  logic                               mixed;
  logic                               push_accepted;
  logic                               is_playing;

  modport source (output valid, sum_left, sum_right, mixed, push_accepted, is_playing,
                  input ready);
  modport sink   (input valid, sum_left, sum_right, mixed, push_accepted, is_playing,
                  output ready);
endinterface

// ===== src/rlrgm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rlrgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rlrgm_ctrl.sv =====
// Controller: sequences one item through accept, execute, interpolation and
// result load, and owns the result valid flag. Depends on rlrgm_pkg.
module rlrgm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  input  rlrgm_pkg::dp_status_t status,
  output rlrgm_pkg::dp_cmd_t    cmd
);

  rlrgm_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlrgm_pkg::S_IDLE: if (in_valid) state_nxt = rlrgm_pkg::S_EXEC;
      rlrgm_pkg::S_EXEC: state_nxt = status.mix_go ? rlrgm_pkg::S_DIFF : rlrgm_pkg::S_FIN;
      rlrgm_pkg::S_DIFF: state_nxt = rlrgm_pkg::S_MUL1;
      rlrgm_pkg::S_MUL1: state_nxt = rlrgm_pkg::S_MUL2;
      rlrgm_pkg::S_MUL2: state_nxt = rlrgm_pkg::S_FIN;
      rlrgm_pkg::S_FIN:  if (out_free) state_nxt = rlrgm_pkg::S_IDLE;
      default:           state_nxt = rlrgm_pkg::S_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      rlrgm_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      rlrgm_pkg::S_EXEC: cmd.exec     = 1'b1;
      rlrgm_pkg::S_DIFF: cmd.diff     = 1'b1;
      rlrgm_pkg::S_MUL1: cmd.mul1     = 1'b1;
      rlrgm_pkg::S_MUL2: cmd.mul2     = 1'b1;
      rlrgm_pkg::S_FIN:  cmd.load_out = out_free;
      default: ;
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlrgm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/rlrgm_dp.sv =====
// Datapath: configuration registers, ring memory and positions, playback flags,
// interpolation and gain arithmetic, result register. Depends on rlrgm_pkg, rlrgm_ram.
module rlrgm_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rlrgm_pkg::dp_cmd_t                     cmd,
  output rlrgm_pkg::dp_status_t                  status,
  input  logic                                   cfg_we,
  input  logic [rlrgm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rlrgm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [rlrgm_pkg::ACT_W-1:0]            action,
  input  logic signed [rlrgm_pkg::SAMP_W-1:0]    in_left,
  input  logic signed [rlrgm_pkg::SAMP_W-1:0]    in_right,
  input  logic signed [rlrgm_pkg::SUM_W-1:0]     accum_left,
  input  logic signed [rlrgm_pkg::SUM_W-1:0]     accum_right,
  output logic signed [rlrgm_pkg::SUM_W-1:0]     sum_left,
  output logic signed [rlrgm_pkg::SUM_W-1:0]     sum_right,
  output logic                                   mixed,
  output logic                                   push_accepted,
  output logic                                   is_playing
);

  localparam int AW     = rlrgm_pkg::RING_AW;
  localparam int CW     = rlrgm_pkg::CNT_W;
  localparam int SW     = rlrgm_pkg::SAMP_W;
  localparam int DW     = SW + 1;
  localparam int PW     = DW + SW;
  localparam int CMP_W  = (CW > rlrgm_pkg::ADV_W) ? CW : rlrgm_pkg::ADV_W;
  localparam logic [CW-1:0] RING_FILL = CW'(rlrgm_pkg::RING_FRAMES);
  localparam logic [CW-1:0] TWO_FILL  = CW'(2);

  // Configuration
  logic [rlrgm_pkg::STEP_W-1:0] step_r;
  logic [rlrgm_pkg::GAIN_W-1:0] gain_r;

  // Item capture
  logic [rlrgm_pkg::ACT_W-1:0] action_r;
  logic signed [SW-1:0]        in_left_r, in_right_r;
  logic signed [rlrgm_pkg::SUM_W-1:0] accum_left_r, accum_right_r;

  // Playback state
  logic [CW-1:0]                write_cnt_r, write_cnt_nxt;
  logic [CW-1:0]                read_cnt_r, read_cnt_nxt;
  logic [rlrgm_pkg::FRAC_W-1:0] phase_r, phase_nxt;
  logic                         playing_r, playing_nxt;
  logic                         src_active_r, src_active_nxt;
  logic                         mixed_r, mixed_nxt;
  logic                         accepted_r, accepted_nxt;

  // Arithmetic pipeline registers
  logic [rlrgm_pkg::T_W-1:0] t_r;
  logic signed [SW-1:0]      a_left_r, a_right_r;
  logic signed [DW-1:0]      d_left_r, d_right_r;
  logic signed [PW-1:0]      p1_left_r, p1_right_r;
  logic signed [PW-1:0]      p2_left_r, p2_right_r;

  // Result register
  logic signed [rlrgm_pkg::SUM_W-1:0] sum_left_r, sum_right_r;
  logic mixed_out_r, accepted_out_r, playing_out_r;

  // Ring memory signals
  logic                            ram_we;
  logic [AW-1:0]                   ram_raddr;
  logic [rlrgm_pkg::FRAME_W-1:0]   ram_rdata;

  // Combinational helpers
  logic [CW-1:0]                 fill;
  logic [rlrgm_pkg::PHACC_W-1:0] phacc;
  logic [rlrgm_pkg::ADV_W-1:0]   adv;
  logic [CW-1:0]                 adv_clamped;
  logic signed [DW-1:0]          d_left, d_right;
  logic signed [DW+1:0]          s_left_w, s_right_w;
  logic signed [DW-1:0]          s_left, s_right;
  logic signed [PW-1:0]          p1_left, p1_right, p2_left, p2_right;
  logic signed [rlrgm_pkg::SUM_W-1:0] add_left, add_right;

  rlrgm_ram #(
    .WIDTH (rlrgm_pkg::FRAME_W),
    .DEPTH (rlrgm_pkg::RING_FRAMES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_cnt_r[AW-1:0]),
    .wdata ({in_right_r, in_left_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read frame a while the item is captured, frame a+1 while it executes
  assign ram_raddr = cmd.exec ? AW'(read_cnt_r + CW'(1)) : read_cnt_r[AW-1:0];

  // Buffered frames and phase advance
  assign fill        = write_cnt_r - read_cnt_r;
  assign phacc       = rlrgm_pkg::PHACC_W'(phase_r) + rlrgm_pkg::PHACC_W'(step_r);
  assign adv         = phacc[rlrgm_pkg::PHACC_W-1:rlrgm_pkg::FRAC_W];
  assign adv_clamped = (CMP_W'(adv) > CMP_W'(fill)) ? fill : CW'(adv);

  assign status.mix_go = (action_r == rlrgm_pkg::ACT_MIX) && playing_r && (fill >= TWO_FILL);

  // Decode the action and update playback state
  always_comb begin
    write_cnt_nxt  = write_cnt_r;
    read_cnt_nxt   = read_cnt_r;
    phase_nxt      = phase_r;
    playing_nxt    = playing_r;
    src_active_nxt = src_active_r;
    mixed_nxt      = 1'b0;
    accepted_nxt   = 1'b0;
    ram_we         = 1'b0;
    unique case (action_r)
      rlrgm_pkg::ACT_PUSH: begin
        if (fill < RING_FILL) begin
          ram_we        = cmd.exec;
          write_cnt_nxt = write_cnt_r + CW'(1);
          accepted_nxt  = 1'b1;
        end
      end
      rlrgm_pkg::ACT_MIX: begin
        if (playing_r) begin
          if (fill < TWO_FILL) begin
            if (!src_active_r) playing_nxt = 1'b0;
          end else begin
            mixed_nxt    = 1'b1;
            read_cnt_nxt = read_cnt_r + adv_clamped;
            phase_nxt    = phacc[rlrgm_pkg::FRAC_W-1:0];
          end
        end
      end
      rlrgm_pkg::ACT_START: begin
        write_cnt_nxt  = '0;
        read_cnt_nxt   = '0;
        phase_nxt      = '0;
        playing_nxt    = 1'b1;
        src_active_nxt = 1'b1;
      end
      rlrgm_pkg::ACT_END: begin
        src_active_nxt = 1'b0;
      end
      rlrgm_pkg::ACT_STOP: begin
        write_cnt_nxt  = '0;
        read_cnt_nxt   = '0;
        phase_nxt      = '0;
        playing_nxt    = 1'b0;
        src_active_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Interpolation: difference, fraction product, base add and gain product
  assign d_left  = DW'(signed'(ram_rdata[SW-1:0]))        - DW'(a_left_r);
  assign d_right = DW'(signed'(ram_rdata[2*SW-1:SW]))     - DW'(a_right_r);
  assign p1_left  = d_left_r  * $signed({1'b0, t_r});
  assign p1_right = d_right_r * $signed({1'b0, t_r});
  assign s_left_w  = (DW+2)'(a_left_r)  + p1_left_r[PW-1:15];
  assign s_right_w = (DW+2)'(a_right_r) + p1_right_r[PW-1:15];
  assign s_left    = s_left_w[DW-1:0];
  assign s_right   = s_right_w[DW-1:0];
  assign p2_left  = s_left  * $signed({1'b0, gain_r});
  assign p2_right = s_right * $signed({1'b0, gain_r});

  // Gain result floored to Q0, sign-extended, and added only when a frame was mixed
  assign add_left  = mixed_r ? rlrgm_pkg::SUM_W'(signed'(p2_left_r[PW-1:14]))  : '0;
  assign add_right = mixed_r ? rlrgm_pkg::SUM_W'(signed'(p2_right_r[PW-1:14])) : '0;

  // Configuration and playback state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= rlrgm_pkg::STEP_RESET;
      gain_r       <= rlrgm_pkg::GAIN_RESET;
      write_cnt_r  <= '0;
      read_cnt_r   <= '0;
      phase_r      <= '0;
      playing_r    <= 1'b0;
      src_active_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rlrgm_pkg::CFG_STEP) begin
          step_r <= cfg_data[rlrgm_pkg::STEP_W-1:0];
        end else begin
          gain_r <= cfg_data[rlrgm_pkg::GAIN_W-1:0];
        end
      end
      if (cmd.exec) begin
        write_cnt_r  <= write_cnt_nxt;
        read_cnt_r   <= read_cnt_nxt;
        phase_r      <= phase_nxt;
        playing_r    <= playing_nxt;
        src_active_r <= src_active_nxt;
      end
    end
  end

  // Item, arithmetic and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r      <= action;
      in_left_r     <= in_left;
      in_right_r    <= in_right;
      accum_left_r  <= accum_left;
      accum_right_r <= accum_right;
    end
    if (cmd.exec) begin
      mixed_r    <= mixed_nxt;
      accepted_r <= accepted_nxt;
      t_r        <= phase_r[rlrgm_pkg::FRAC_W-1:1];
      a_left_r   <= ram_rdata[SW-1:0];
      a_right_r  <= ram_rdata[2*SW-1:SW];
    end
    if (cmd.diff) begin
      d_left_r  <= d_left;
      d_right_r <= d_right;
    end
    if (cmd.mul1) begin
      p1_left_r  <= p1_left;
      p1_right_r <= p1_right;
    end
    if (cmd.mul2) begin
      p2_left_r  <= p2_left;
      p2_right_r <= p2_right;
    end
    if (cmd.load_out) begin
      sum_left_r     <= accum_left_r + add_left;
      sum_right_r    <= accum_right_r + add_right;
      mixed_out_r    <= mixed_r;
      accepted_out_r <= accepted_r;
      playing_out_r  <= playing_r;
    end
  end

  assign sum_left      = sum_left_r;
  assign sum_right     = sum_right_r;
  assign mixed         = mixed_out_r;
  assign push_accepted = accepted_out_r;
  assign is_playing    = playing_out_r;

endmodule

// ===== src/ring_linear_resample_gain_mixer_unit.sv =====
// Top level of the ring buffer linear-interpolation resampler and gain mixer.
// Depends on rlrgm_pkg, rlrgm_in_if, rlrgm_out_if, rlrgm_ctrl, rlrgm_dp.
//
// The unit handles one item at a time. Push, start, input-ended, stop and
// non-mixing mix items pass through accept, execute and result load; a mix that
// adds a frame also passes through a difference, a fraction multiply and a gain
// multiply, one register apart, since both ring frames come from the single read
// port of the ring memory. The next item is taken as soon as the previous result
// sits in the output register, even if it has not been transferred yet; a finished
// item waits for its load while the result side stalls an untransferred one. The
// ring needs no clearing pass after reset. Configuration writes are taken at any
// clock edge with cfg_we high and must only happen while no item is in flight.
module ring_linear_resample_gain_mixer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  rlrgm_in_if.sink                           in_ch,
  rlrgm_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [rlrgm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlrgm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rlrgm_pkg::dp_cmd_t    cmd;
  rlrgm_pkg::dp_status_t status;

  rlrgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  rlrgm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (in_ch.action),
    .in_left       (in_ch.in_left),
    .in_right      (in_ch.in_right),
    .accum_left    (in_ch.accum_left),
    .accum_right   (in_ch.accum_right),
    .sum_left      (out_ch.sum_left),
    .sum_right     (out_ch.sum_right),
    .mixed         (out_ch.mixed),
    .push_accepted (out_ch.push_accepted),
    .is_playing    (out_ch.is_playing)
  );

endmodule

// ===== src/rlrgm_checker.sv =====
// Port-level checker for the resampler / gain mixer, bound to the top level.
// Depends on rlrgm_pkg and ring_linear_resample_gain_mixer_unit.
module rlrgm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [rlrgm_pkg::SUM_W-1:0] sum_left,
  input logic                               mixed,
  input logic                               push_accepted,
  input logic                               is_playing
);

  // Hold the result while it is stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sum_left))
    else $error("result changed while stalled");

  // One item at a time: no transfer in the cycle after an input transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // A result is either a mix or a push outcome, never both
  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(mixed && push_accepted))
    else $error("mixed and push_accepted both set");

  // Mixing a frame only happens while playing, and leaves playback on
  a_mix_plays: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mixed |-> is_playing)
    else $error("frame mixed while not playing");

endmodule

bind ring_linear_resample_gain_mixer_unit rlrgm_checker u_rlrgm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .sum_left      (out_ch.sum_left),
  .mixed         (out_ch.mixed),
  .push_accepted (out_ch.push_accepted),
  .is_playing    (out_ch.is_playing)
);

// ===== tb/ring_linear_resample_gain_mixer_unit_tb.sv =====
// Testbench for ring_linear_resample_gain_mixer_unit: directed table, then random playback
// sessions, scored against a cycle-free predictor or, for typed table rows, their listed results.
// Depends on rlrgm_pkg, rlrgm_in_if, rlrgm_out_if and the RTL of the unit.
module ring_linear_resample_gain_mixer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlrgm_pkg::*;

  // Action codes the unit ignores
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  localparam int  RESET_CYCLES  = 10;
  localparam int  LONG_HOLD     = 300;
  localparam int  REPORT_LIMIT  = 10;
  localparam int  PLAY_SESSIONS = 8;
  localparam int  SESSION_BODY  = 75;
  localparam longint RUN_LIMIT_NS = 15_000_000;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [SAMP_W-1:0] left;
    logic signed [SAMP_W-1:0] right;
    logic signed [SUM_W-1:0]  accl;
    logic signed [SUM_W-1:0]  accr;
  } mix_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_l;
    logic signed [SUM_W-1:0] sum_r;
    logic                    mixed;
    logic                    accepted;
    logic                    playing;
  } mix_res_t;

  typedef struct packed {
    mix_req_t req;
    logic     typed;
    mix_res_t res;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rlrgm_in_if  in_ch();
  rlrgm_out_if out_ch();

  ring_linear_resample_gain_mixer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the unit's state and registers
  logic [FRAME_W-1:0] p_ring [RING_FRAMES];
  logic [CNT_W-1:0]   p_wr;
  logic [CNT_W-1:0]   p_rd;
  logic [FRAC_W-1:0]  p_phase;
  logic               p_playing;
  logic               p_active;
  logic [STEP_W-1:0]  p_step;
  logic [GAIN_W-1:0]  p_gain;

  mix_res_t expected_sums [$];
  dir_row_t dir_rows [$];
  int       failures;
  int       results_seen;
  bit       send_eager;
  bit       sink_eager;
  bit       sink_hold;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Interpolate one channel between two frames, then apply the Q14 gain (floor shifts)
  function automatic logic signed [SUM_W-1:0] scaled_lerp(input logic signed [SAMP_W-1:0] a,
                                                          input logic signed [SAMP_W-1:0] b,
                                                          input logic [T_W-1:0] t,
                                                          input logic [GAIN_W-1:0] g);
    longint sa;
    longint sb;
    longint s;
    sa = a;
    sb = b;
    s  = sa + (((sb - sa) * longint'(t)) >>> 15);
    s  = (s * longint'(g)) >>> 14;
    return s[SUM_W-1:0];
  endfunction

  // Advance the predictor by one item and return the result it should produce
  task automatic predict_mix_result(input mix_req_t req, output mix_res_t res);
    logic [CNT_W-1:0]   fill;
    logic [CNT_W-1:0]   rd_next;
    logic [CNT_W-1:0]   adv;
    logic [FRAME_W-1:0] fa;
    logic [FRAME_W-1:0] fb;
    logic [PHACC_W-1:0] acc;
    res.sum_l    = req.accl;
    res.sum_r    = req.accr;
    res.mixed    = 1'b0;
    res.accepted = 1'b0;
    fill = p_wr - p_rd;
    case (req.action)
      ACT_PUSH: begin
        if (fill < RING_FRAMES) begin
          p_ring[p_wr[RING_AW-1:0]] = {req.right, req.left};
          p_wr = p_wr + 1'b1;
          res.accepted = 1'b1;
        end
      end
      ACT_MIX: begin
        if (p_playing && fill < 2) begin
          // underrun: stop only once the source has finished
          if (!p_active) p_playing = 1'b0;
        end else if (p_playing) begin
          rd_next = p_rd + 1'b1;
          fa = p_ring[p_rd[RING_AW-1:0]];
          fb = p_ring[rd_next[RING_AW-1:0]];
          res.sum_l = req.accl + scaled_lerp(fa[SAMP_W-1:0], fb[SAMP_W-1:0],
                                             p_phase[FRAC_W-1:1], p_gain);
          res.sum_r = req.accr + scaled_lerp(fa[FRAME_W-1:SAMP_W], fb[FRAME_W-1:SAMP_W],
                                             p_phase[FRAC_W-1:1], p_gain);
          res.mixed = 1'b1;
          // advance the read position, never past the write position
          acc = {1'b0, p_phase} + {1'b0, p_step};
          adv = CNT_W'(acc[PHACC_W-1:FRAC_W]);
          if (adv > fill) adv = fill;
          p_rd    = p_rd + adv;
          p_phase = acc[FRAC_W-1:0];
        end
      end
      ACT_START: begin
        p_wr      = '0;
        p_rd      = '0;
        p_phase   = '0;
        p_playing = 1'b1;
        p_active  = 1'b1;
      end
      ACT_END: p_active = 1'b0;
      ACT_STOP: begin
        p_wr      = '0;
        p_rd      = '0;
        p_phase   = '0;
        p_playing = 1'b0;
        p_active  = 1'b0;
      end
      default: ;
    endcase
    res.playing = p_playing;
  endtask

  // Mostly short gaps, a few long ones, none at all in eager stretches
  function automatic int pick_gap(input bit eager);
    int r;
    r = $urandom_range(0, 99);
    if (eager || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random field value with its extremes, zero and all-ones mixed in
  function automatic logic [31:0] rand_bits(input int w);
    logic [31:0] top;
    top = 32'h1 << (w - 1);
    case ($urandom_range(0, 15))
      0: return top - 1;
      1: return top;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic mix_req_t random_req(input logic [ACT_W-1:0] act);
    mix_req_t r;
    r.action = act;
    r.left   = SAMP_W'(rand_bits(SAMP_W));
    r.right  = SAMP_W'(rand_bits(SAMP_W));
    r.accl   = rand_bits(SUM_W);
    r.accr   = rand_bits(SUM_W);
    return r;
  endfunction

  // Offer one item, hold it until the transfer, record its expected result
  task automatic send_item(input mix_req_t req, input logic typed, input mix_res_t typed_res);
    mix_res_t pred;
    int       gap;
    in_ch.valid       <= 1'b1;
    in_ch.action      <= req.action;
    in_ch.in_left     <= req.left;
    in_ch.in_right    <= req.right;
    in_ch.accum_left  <= req.accl;
    in_ch.accum_right <= req.accr;
    do @(posedge clk); while (!in_ch.ready);
    predict_mix_result(req, pred);
    expected_sums.push_back(typed ? typed_res : pred);
    @(negedge clk);
    gap = pick_gap(send_eager);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_action(input logic [ACT_W-1:0] act);
    send_item(random_req(act), 1'b0, '0);
  endtask

  // Drop valid and wait until every expected result has been transferred
  task automatic settle_results();
    in_ch.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both registers on back-to-back edges while the unit is idle
  task automatic write_regs(input logic [STEP_W-1:0] step, input logic [GAIN_W-1:0] gain);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP;
    cfg_data  <= step;
    @(negedge clk);
    cfg_index <= CFG_GAIN;
    cfg_data  <= {{(CFG_DATA_W-GAIN_W){1'b0}}, gain};
    @(negedge clk);
    cfg_we <= 1'b0;
    p_step = step;
    p_gain = gain;
  endtask

  task automatic add_row(input logic [ACT_W-1:0] act, input logic [15:0] l, input logic [15:0] r,
                         input logic [31:0] al, input logic [31:0] ar, input logic typed,
                         input logic mx, input logic ac, input logic pl);
    dir_row_t row;
    row.req.action   = act;
    row.req.left     = l;
    row.req.right    = r;
    row.req.accl     = al;
    row.req.accr     = ar;
    row.typed        = typed;
    row.res.sum_l    = al;
    row.res.sum_r    = ar;
    row.res.mixed    = mx;
    row.res.accepted = ac;
    row.res.playing  = pl;
    dir_rows.push_back(row);
  endtask

  // One playback session: mostly pushes and mixes with some control and noise,
  // then end of input, three to twelve mixes toward underrun, and usually stop
  task automatic run_playback_session(input int body_len);
    int               pick;
    logic [ACT_W-1:0] act;
    send_action(ACT_START);
    repeat (body_len) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) act = ACT_PUSH;
      else if (pick < 86) act = ACT_MIX;
      else if (pick < 89) act = ACT_END;
      else if (pick < 91) act = ACT_START;
      else if (pick < 93) act = ACT_STOP;
      else if (pick < 97) act = ACT_UNUSED_LO + ACT_W'($urandom_range(0, 2));
      else act = ACT_W'($urandom);
      send_action(act);
    end
    send_action(ACT_END);
    repeat ($urandom_range(3, 12)) send_action(ACT_MIX);
    if ($urandom_range(0, 3) != 0) send_action(ACT_STOP);
  endtask

  // Score each result transfer against the oldest expectation
  always @(posedge clk) begin
    mix_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_sums.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: result with nothing expected: sum %h/%h flags %b%b%b",
                   out_ch.sum_left, out_ch.sum_right, out_ch.mixed,
                   out_ch.push_accepted, out_ch.is_playing);
      end else begin
        want = expected_sums.pop_front();
        if (out_ch.sum_left !== want.sum_l || out_ch.sum_right !== want.sum_r ||
            out_ch.mixed !== want.mixed || out_ch.push_accepted !== want.accepted ||
            out_ch.is_playing !== want.playing) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("ERROR: result %0d: sum_left %h/%h sum_right %h/%h mixed %b/%b %s",
                     results_seen, out_ch.sum_left, want.sum_l, out_ch.sum_right,
                     want.sum_r, out_ch.mixed, want.mixed,
                     $sformatf("push_accepted %b/%b is_playing %b/%b (actual/expected)",
                               out_ch.push_accepted, want.accepted,
                               out_ch.is_playing, want.playing));
        end
      end
    end
  end

  // Result side: random stalls, eager stretches, and the long hold-off
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (sink_hold) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap(sink_eager);
      end
    end
  end

  // Hold the result side off long enough for the unit to back up into its input
  initial begin : long_hold
    int c;
    sink_hold = 1'b0;
    wait (results_seen >= 150);
    @(posedge clk);
    sink_hold = 1'b1;
    for (c = 0; c < LONG_HOLD; c++) @(posedge clk);
    sink_hold = 1'b0;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAIL ring_linear_resample_gain_mixer_unit");
    $finish;
  end

  initial begin : stimulus
    logic [STEP_W-1:0] st;
    logic [GAIN_W-1:0] gn;
    failures     = 0;
    results_seen = 0;
    send_eager   = 1'b0;
    sink_eager   = 1'b0;
    p_wr         = '0;
    p_rd         = '0;
    p_phase      = '0;
    p_playing    = 1'b0;
    p_active     = 1'b0;
    p_step       = STEP_RESET;
    p_gain       = GAIN_RESET;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_STEP;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_PUSH;
    in_ch.in_left     = '0;
    in_ch.in_right    = '0;
    in_ch.accum_left  = '0;
    in_ch.accum_right = '0;

    // Directed table; typed rows pass the accumulators through unchanged
    //      action          left      right     accum_left    accum_right  typ mx ac pl
    add_row(ACT_MIX,       16'h0000, 16'h0000, 32'h7FFFFFFF, 32'h80000000,
            1'b1, 1'b0, 1'b0, 1'b0);
    add_row(ACT_UNUSED_LO, 16'h7FFF, 16'h8000, 32'h12345678, 32'hFFFFFFFF,
            1'b1, 1'b0, 1'b0, 1'b0);
    add_row(ACT_PUSH,      16'h7FFF, 16'h8000, 32'h00000000, 32'h00000000,
            1'b1, 1'b0, 1'b1, 1'b0);
    add_row(ACT_START,     16'hFFFF, 16'hFFFF, 32'h00000005, 32'hFFFFFFFB,
            1'b1, 1'b0, 1'b0, 1'b1);
    add_row(ACT_MIX,       16'h0000, 16'h0000, 32'h00000001, 32'h00000002,
            1'b1, 1'b0, 1'b0, 1'b1);
    add_row(ACT_PUSH,      16'h7FFF, 16'h8000, 32'h00000000, 32'h00000000,
            1'b1, 1'b0, 1'b1, 1'b1);
    add_row(ACT_MIX,       16'h0000, 16'h0000, 32'h00000003, 32'h00000004,
            1'b1, 1'b0, 1'b0, 1'b1);
    add_row(ACT_PUSH,      16'h8000, 16'h7FFF, 32'h80000000, 32'h7FFFFFFF,
            1'b1, 1'b0, 1'b1, 1'b1);
    add_row(ACT_PUSH,      16'hFFFF, 16'h0001, 32'h00000000, 32'h00000000,
            1'b1, 1'b0, 1'b1, 1'b1);
    add_row(ACT_MIX,       16'h0000, 16'h0000, 32'h7FFFFFFF, 32'h80000000,
            1'b0, 1'b0, 1'b0, 1'b0);
    add_row(ACT_MIX,       16'hAAAA, 16'h5555, 32'h00000000, 32'hFFFFFFFF,
            1'b0, 1'b0, 1'b0, 1'b0);
    add_row(ACT_UNUSED_LO + 3'd1, 16'h5555, 16'hAAAA, 32'hDEADBEEF, 32'h0,
            1'b1, 1'b0, 1'b0, 1'b1);
    add_row(ACT_END,       16'h0000, 16'h0000, 32'h00000009, 32'h00000009,
            1'b1, 1'b0, 1'b0, 1'b1);
    add_row(ACT_MIX,       16'h0000, 16'h0000, 32'h80000000, 32'h80000000,
            1'b1, 1'b0, 1'b0, 1'b0);
    add_row(ACT_MIX,       16'h0000, 16'h0000, 32'hFFFFFFFF, 32'h7FFFFFFF,
            1'b1, 1'b0, 1'b0, 1'b0);
    add_row(ACT_PUSH,      16'h1234, 16'hFEDC, 32'h00000011, 32'h00000022,
            1'b1, 1'b0, 1'b1, 1'b0);
    add_row(ACT_START,     16'h0000, 16'h0000, 32'h00000000, 32'h00000000,
            1'b1, 1'b0, 1'b0, 1'b1);
    add_row(ACT_PUSH,      16'h0001, 16'hFFFF, 32'h00000000, 32'h00000000,
            1'b1, 1'b0, 1'b1, 1'b1);
    add_row(ACT_PUSH,      16'h8000, 16'h8000, 32'h00000000, 32'h00000000,
            1'b1, 1'b0, 1'b1, 1'b1);
    add_row(ACT_PUSH,      16'h7FFF, 16'h7FFF, 32'h00000000, 32'h00000000,
            1'b1, 1'b0, 1'b1, 1'b1);
    add_row(ACT_STOP,      16'h0000, 16'h0000, 32'h7FFFFFFF, 32'h7FFFFFFF,
            1'b1, 1'b0, 1'b0, 1'b0);
    add_row(ACT_MIX,       16'h0000, 16'h0000, 32'h00000077, 32'h00000088,
            1'b1, 1'b0, 1'b0, 1'b0);
    add_row(ACT_UNUSED_HI, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            1'b1, 1'b0, 1'b0, 1'b0);
    add_row(ACT_PUSH,      16'h8000, 16'h7FFF, 32'h00000000, 32'h00000000,
            1'b1, 1'b0, 1'b1, 1'b0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    settle_results();

    // Random sessions, the first three at the register extremes and reset values
    for (int ses = 0; ses < PLAY_SESSIONS; ses++) begin
      case (ses)
        0: begin st = '0; gn = GAIN_MAX; end
        1: begin st = STEP_MAX; gn = '0; end
        2: begin st = STEP_RESET; gn = GAIN_RESET; end
        default: begin
          st = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom)
                                           : STEP_W'($urandom_range(1, 20'h28000));
          gn = ($urandom_range(0, 3) == 0) ? GAIN_RESET : GAIN_W'($urandom);
        end
      endcase
      send_eager = ($urandom_range(0, 3) == 0);
      sink_eager = ($urandom_range(0, 3) == 0);
      write_regs(st, gn);
      run_playback_session(SESSION_BODY);
      settle_results();
    end

    repeat (12) @(posedge clk);
    if (failures == 0)
      $display("PASS ring_linear_resample_gain_mixer_unit");
    else
      $display("FAIL ring_linear_resample_gain_mixer_unit");
    $finish;
  end

endmodule

// ===== ring_linear_resample_gain_mixer_unit.f =====
src/rlrgm_pkg.sv
src/rlrgm_in_if.sv
src/rlrgm_out_if.sv
src/rlrgm_ram.sv
src/rlrgm_ctrl.sv
src/rlrgm_dp.sv
src/ring_linear_resample_gain_mixer_unit.sv
src/rlrgm_checker.sv
tb/ring_linear_resample_gain_mixer_unit_tb.sv
